### hw/rtl/hpc_pkg.sv
// Shared types and constants of the hexatic pair-correlation histogram.
// Used by every module of the block but hpc_ram; depends on nothing else.
package hpc_pkg;

   localparam int POS_W      = 20;
   localparam int ORD_W      = 16;
   localparam int BOX_W      = 13;
   localparam int CNT_W      = 11;
   localparam int CMD_W      = 2;
   localparam int IDX_W      = 10;
   localparam int OUT_BIN_W  = 6;
   localparam int SUM_W      = 64;
   localparam int TALLY_W    = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam int PROD_W     = 35;
   localparam int QUO_W      = 7;

   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FRAME   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READOUT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_MIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_MAX  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_STEP = 3'd5;

   typedef struct packed {
      logic        [POS_W-1:0] x;
      logic        [POS_W-1:0] y;
      logic signed [ORD_W-1:0] re;
      logic signed [ORD_W-1:0] im;
   } point_type;

   typedef enum logic {GEO_PAIR, GEO_NBINS} geo_op_type;

   typedef struct packed {
      logic [BOX_W-1:0] box_w;
      logic [BOX_W-1:0] box_h;
      logic [POS_W-1:0] r_min;
      logic [POS_W-1:0] r_max;
      logic [POS_W-1:0] r_step;
   } geo_cfg_type;

   typedef struct packed {
      logic       start;
      geo_op_type op;
      point_type  pa;
      point_type  pb;
   } geo_req_type;

   typedef struct packed {
      logic                     done;
      logic                     hit;
      logic [QUO_W-1:0]         quot;
      logic signed [PROD_W-1:0] re;
      logic signed [PROD_W-1:0] im;
   } geo_rsp_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] re_sum;
      logic signed [SUM_W-1:0] im_sum;
      logic [TALLY_W-1:0]      tally;
   } bin_type;

endpackage

### hw/rtl/hexatic_pair_corr_histogram.sv
// Hexatic pair-correlation histogram, top level. Depends on hpc_pkg,
// hpc_ram and hpc_geom.
//
// The block holds one frame of points in a point memory and a radial
// histogram of psi_i*conj(psi_j) sums and pair tallies in a bin memory.
// A load word writes one point slot; a clear word empties the histogram
// by clearing the valid bit that each bin carries, since a bin that is
// not valid reads as zero. An end-frame word first works out the bin
// count and then visits every pair i<j of the first point_count slots
// (at most MAX_POINTS). Each pair is handled by one shared bit-serial
// arithmetic unit, which forms the products, folds both offsets into the
// periodic box, squares, takes the integer square root one result bit per
// cycle and divides into a bin; if the pair falls in a bin in use, the
// bin is read, updated with saturation and written back. req_stall stays
// high throughout the frame pass. The read-modify-write of one pair
// finishes before the next pair starts, so no forwarding is needed on
// the bin memory. A readout word emits one response word per bin in
// use; the next input word may be taken while the last response still
// waits. Configuration must be written only while the block is idle;
// the block itself does not enforce this.
module hexatic_pair_corr_histogram import hpc_pkg::*; #(
   parameter int MAX_POINTS = 1024,
   parameter int MAX_BINS   = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CMD_W-1:0]        req_command,
   input  logic [IDX_W-1:0]        req_point_index,
   input  logic [POS_W-1:0]        req_pos_x,
   input  logic [POS_W-1:0]        req_pos_y,
   input  logic signed [ORD_W-1:0] req_order_re,
   input  logic signed [ORD_W-1:0] req_order_im,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [OUT_BIN_W-1:0]    rsp_bin_index,
   output logic signed [SUM_W-1:0] rsp_corr_real_sum,
   output logic signed [SUM_W-1:0] rsp_corr_imag_sum,
   output logic [TALLY_W-1:0]      rsp_pair_tally,
   output logic                    rsp_last_bin,
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data
);

   localparam int PT_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int NC_A  = $clog2(MAX_POINTS + 1);
   localparam int NCW   = (NC_A > CNT_W) ? NC_A : CNT_W;
   localparam int HW    = $bits(bin_type);

   typedef enum logic [3:0] {
      S_IDLE, S_NB, S_NB_WAIT, S_RD_I, S_CAP_I, S_RD_J, S_PAIR, S_PAIR_WAIT,
      S_UPD, S_NEXT, S_RO_RD, S_RO_CAP
   } state_type;

   // Configuration registers.
   logic [BOX_W-1:0] box_w_ff, box_h_ff;
   logic [CNT_W-1:0] pcount_ff;
   logic [POS_W-1:0] r_min_ff, r_max_ff, r_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_w_ff  <= 13'd256;
         box_h_ff  <= 13'd256;
         pcount_ff <= 11'd1024;
         r_min_ff  <= 20'd0;
         r_max_ff  <= 20'd8192;
         r_step_ff <= 20'd256;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BOX_WIDTH:   box_w_ff  <= csr_write_data[BOX_W-1:0];
            CSR_BOX_HEIGHT:  box_h_ff  <= csr_write_data[BOX_W-1:0];
            CSR_POINT_COUNT: pcount_ff <= csr_write_data[CNT_W-1:0];
            CSR_RADIUS_MIN:  r_min_ff  <= csr_write_data;
            CSR_RADIUS_MAX:  r_max_ff  <= csr_write_data;
            CSR_RADIUS_STEP: r_step_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   state_type                state_ff;
   logic                     op_frame_ff;
   logic [NCW-1:0]           n_ff, i_ff, j_ff;
   logic [BIN_W:0]           nb_ff, nb_in, k_ff;
   point_type                pi_ff;
   logic [BIN_W-1:0]         bin_ff;
   logic signed [PROD_W-1:0] add_re_ff, add_im_ff;
   logic [MAX_BINS-1:0]      valid_ff;
   logic                     ok_ff;
   logic                     rsp_valid_ff, rsp_last_ff;
   logic [OUT_BIN_W-1:0]     rsp_bin_ff;
   bin_type                  rsp_data_ff;

   logic                     req_take, load_ok;
   logic [IDX_W+PT_W-1:0]    idx_ext;
   logic [NCW-1:0]           n_in;
   point_type                wr_point, pt_rd_data;
   logic                     pt_rd_en;
   logic [PT_W-1:0]          pt_rd_addr;
   logic                     hist_rd_en, hist_wr_en, pair_in_range;
   logic [BIN_W-1:0]         hist_rd_addr;
   logic [HW-1:0]            hist_rd_raw;
   bin_type                  ent, upd;
   logic signed [SUM_W:0]    s_re, s_im;
   geo_cfg_type              geo_cfg;
   geo_req_type              geo_req;
   geo_rsp_type              geo_rsp;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign idx_ext   = (IDX_W + PT_W)'(req_point_index);
   assign load_ok   = req_take && (req_command == CMD_LOAD) &&
                      (int'(req_point_index) < MAX_POINTS);
   assign n_in      = (int'(pcount_ff) > MAX_POINTS) ? NCW'(MAX_POINTS)
                                                     : NCW'(pcount_ff);

   assign wr_point.x  = req_pos_x;
   assign wr_point.y  = req_pos_y;
   assign wr_point.re = req_order_re;
   assign wr_point.im = req_order_im;

   assign pt_rd_en   = (state_ff == S_RD_I) || (state_ff == S_RD_J);
   assign pt_rd_addr = (state_ff == S_RD_I) ? i_ff[PT_W-1:0] : j_ff[PT_W-1:0];

   hpc_ram #(.WIDTH($bits(point_type)), .DEPTH(MAX_POINTS)) u_points (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (idx_ext[PT_W-1:0]),
      .wr_data (wr_point),
      .rd_en   (pt_rd_en),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   // Arithmetic unit.
   assign geo_cfg.box_w  = box_w_ff;
   assign geo_cfg.box_h  = box_h_ff;
   assign geo_cfg.r_min  = r_min_ff;
   assign geo_cfg.r_max  = r_max_ff;
   assign geo_cfg.r_step = r_step_ff;
   assign geo_req.start  = (state_ff == S_NB) || (state_ff == S_PAIR);
   assign geo_req.op     = (state_ff == S_NB) ? GEO_NBINS : GEO_PAIR;
   assign geo_req.pa     = pi_ff;
   assign geo_req.pb     = pt_rd_data;

   hpc_geom u_geom (
      .clock   (clock),
      .reset   (reset),
      .cfg     (geo_cfg),
      .geo_req (geo_req),
      .geo_rsp (geo_rsp)
   );

   assign nb_in = (int'(geo_rsp.quot) >= MAX_BINS) ? (BIN_W + 1)'(MAX_BINS)
                                                   : (BIN_W + 1)'(geo_rsp.quot);
   assign pair_in_range = geo_rsp.hit && (int'(geo_rsp.quot) < int'(nb_ff));

   // Bin memory: read in the pair wait or readout read state; a pair's bin
   // is written back in the next cycle with the saturated sums.
   assign hist_rd_en = ((state_ff == S_PAIR_WAIT) && geo_rsp.done && pair_in_range) ||
                       ((state_ff == S_RO_RD) && (!rsp_valid_ff || !rsp_stall));
   assign hist_rd_addr = (state_ff == S_RO_RD) ? k_ff[BIN_W-1:0]
                                               : geo_rsp.quot[BIN_W-1:0];
   assign hist_wr_en = (state_ff == S_UPD);

   always_comb begin
      ent  = ok_ff ? bin_type'(hist_rd_raw) : '0;
      s_re = (SUM_W + 1)'(ent.re_sum) + (SUM_W + 1)'(add_re_ff);
      s_im = (SUM_W + 1)'(ent.im_sum) + (SUM_W + 1)'(add_im_ff);
      if (s_re[SUM_W] != s_re[SUM_W-1]) begin
         upd.re_sum = s_re[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                  : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         upd.re_sum = s_re[SUM_W-1:0];
      end
      if (s_im[SUM_W] != s_im[SUM_W-1]) begin
         upd.im_sum = s_im[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                  : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         upd.im_sum = s_im[SUM_W-1:0];
      end
      if (ent.tally >= {{(TALLY_W-1){1'b1}}, 1'b0}) begin
         upd.tally = '1;
      end else begin
         upd.tally = ent.tally + TALLY_W'(2);
      end
   end

   hpc_ram #(.WIDTH(HW), .DEPTH(MAX_BINS)) u_hist (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (bin_ff),
      .wr_data (upd),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_raw)
   );

   // Sequencer.
   always_ff @(posedge clock) begin
      if (hist_rd_en) begin
         ok_ff <= valid_ff[hist_rd_addr];
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_command)
                  CMD_FRAME: begin
                     op_frame_ff <= 1'b1;
                     n_ff        <= n_in;
                     state_ff    <= S_NB;
                  end
                  CMD_CLEAR:   valid_ff <= '0;
                  CMD_READOUT: begin
                     op_frame_ff <= 1'b0;
                     state_ff    <= S_NB;
                  end
                  default: ;
               endcase
            end
         end
         S_NB: state_ff <= S_NB_WAIT;
         S_NB_WAIT: begin
            if (geo_rsp.done) begin
               nb_ff <= nb_in;
               i_ff  <= '0;
               k_ff  <= '0;
               if (op_frame_ff) begin
                  state_ff <= (n_ff < NCW'(2)) ? S_IDLE : S_RD_I;
               end else begin
                  state_ff <= (nb_in == '0) ? S_IDLE : S_RO_RD;
               end
            end
         end
         S_RD_I: state_ff <= S_CAP_I;
         S_CAP_I: begin
            pi_ff    <= pt_rd_data;
            j_ff     <= i_ff + NCW'(1);
            state_ff <= S_RD_J;
         end
         S_RD_J: state_ff <= S_PAIR;
         S_PAIR: state_ff <= S_PAIR_WAIT;
         S_PAIR_WAIT: begin
            if (geo_rsp.done) begin
               bin_ff    <= geo_rsp.quot[BIN_W-1:0];
               add_re_ff <= geo_rsp.re;
               add_im_ff <= geo_rsp.im;
               state_ff  <= pair_in_range ? S_UPD : S_NEXT;
            end
         end
         S_UPD: begin
            valid_ff[bin_ff] <= 1'b1;
            state_ff         <= S_NEXT;
         end
         S_NEXT: begin
            if (j_ff + NCW'(1) < n_ff) begin
               j_ff     <= j_ff + NCW'(1);
               state_ff <= S_RD_J;
            end else if (i_ff + NCW'(2) < n_ff) begin
               i_ff     <= i_ff + NCW'(1);
               state_ff <= S_RD_I;
            end else begin
               state_ff <= S_IDLE;
            end
         end
         S_RO_RD: begin
            if (hist_rd_en) begin
               state_ff <= S_RO_CAP;
            end
         end
         S_RO_CAP: begin
            rsp_valid_ff <= 1'b1;
            rsp_bin_ff   <= OUT_BIN_W'(k_ff);
            rsp_data_ff  <= ok_ff ? bin_type'(hist_rd_raw) : '0;
            rsp_last_ff  <= (k_ff + (BIN_W + 1)'(1) == nb_ff);
            k_ff         <= k_ff + (BIN_W + 1)'(1);
            state_ff     <= (k_ff + (BIN_W + 1)'(1) == nb_ff) ? S_IDLE : S_RO_RD;
         end
         default: state_ff <= S_IDLE;
      endcase
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bin_index     = rsp_bin_ff;
   assign rsp_corr_real_sum = rsp_data_ff.re_sum;
   assign rsp_corr_imag_sum = rsp_data_ff.im_sum;
   assign rsp_pair_tally    = rsp_data_ff.tally;
   assign rsp_last_bin      = rsp_last_ff;

endmodule

### hw/rtl/hpc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Stands alone; used for the point store and the histogram.
module hpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/hpc_geom.sv
// Sequential arithmetic unit: pair products, minimum-image folding, square,
// bit-serial square root and bin division. Depends on hpc_pkg.
module hpc_geom import hpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  geo_cfg_type cfg,
   input  geo_req_type geo_req,
   output geo_rsp_type geo_rsp
);

   typedef enum logic [2:0] {
      S_IDLE, S_PROD, S_MOD, S_FOLD, S_SQ, S_SQRT, S_CHECK, S_DIV
   } state_type;

   state_type                state_ff;
   logic [4:0]               cnt_ff;
   point_type                pa_ff, pb_ff;
   logic [20:0]              lenx_ff, leny_ff, remx_ff, remy_ff;
   logic [19:0]              absx_ff, absy_ff;
   logic [41:0]              sq_ff, res_ff, bit_ff;
   logic [21:0]              num_ff;
   logic [19:0]              den_ff;
   logic [QUO_W-1:0]         quot_ff;
   logic signed [PROD_W-1:0] re_ff, im_ff;
   logic                     hit_ff, done_ff;

   logic signed [ORD_W-1:0]  mul_a, mul_b;
   logic signed [31:0]       prod;
   logic [33:0]              shx, shy;
   logic [19:0]              sq_op;
   logic [39:0]              sqp;
   logic [41:0]              trial;
   logic [26:0]              dsh;
   logic [20:0]              diffx, diffy;
   logic [19:0]              step_nz;
   logic [BOX_W-1:0]         bw_nz, bh_nz;
   logic [21:0]              dist_root;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    begin mul_a = pa_ff.re; mul_b = pb_ff.re; end
         2'd1:    begin mul_a = pa_ff.im; mul_b = pb_ff.im; end
         2'd2:    begin mul_a = pa_ff.im; mul_b = pb_ff.re; end
         default: begin mul_a = pa_ff.re; mul_b = pb_ff.im; end
      endcase
      prod      = mul_a * mul_b;
      shx       = 34'(lenx_ff) << cnt_ff[3:0];
      shy       = 34'(leny_ff) << cnt_ff[3:0];
      sq_op     = cnt_ff[0] ? absy_ff : absx_ff;
      sqp       = sq_op * sq_op;
      trial     = res_ff + bit_ff;
      dsh       = 27'(den_ff) << cnt_ff[2:0];
      diffx     = {1'b0, geo_req.pa.x} - {1'b0, geo_req.pb.x};
      diffy     = {1'b0, geo_req.pa.y} - {1'b0, geo_req.pb.y};
      step_nz   = (cfg.r_step == '0) ? 20'd1 : cfg.r_step;
      bw_nz     = (cfg.box_w == '0) ? 13'd1 : cfg.box_w;
      bh_nz     = (cfg.box_h == '0) ? 13'd1 : cfg.box_h;
      dist_root = res_ff[21:0];
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (geo_req.start) begin
               pa_ff   <= geo_req.pa;
               pb_ff   <= geo_req.pb;
               lenx_ff <= {bw_nz, 8'd0};
               leny_ff <= {bh_nz, 8'd0};
               remx_ff <= diffx[20] ? 21'(-diffx) : diffx;
               remy_ff <= diffy[20] ? 21'(-diffy) : diffy;
               quot_ff <= '0;
               hit_ff  <= 1'b1;
               den_ff  <= step_nz;
               num_ff  <= 22'(cfg.r_max - cfg.r_min);
               cnt_ff  <= '0;
               if (geo_req.op == GEO_PAIR) begin
                  state_ff <= S_PROD;
               end else if (cfg.r_max <= cfg.r_min) begin
                  done_ff <= 1'b1;
               end else begin
                  cnt_ff   <= 5'd7;
                  state_ff <= S_DIV;
               end
            end
         end
         S_PROD: begin
            case (cnt_ff[1:0])
               2'd0:    re_ff <= PROD_W'(prod);
               2'd1:    re_ff <= re_ff + PROD_W'(prod);
               2'd2:    im_ff <= PROD_W'(prod);
               default: im_ff <= im_ff - PROD_W'(prod);
            endcase
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_ff   <= 5'd12;
               state_ff <= S_MOD;
            end else begin
               cnt_ff <= cnt_ff + 5'd1;
            end
         end
         S_MOD: begin
            // Restoring reduction of each offset modulo the box length.
            if (34'(remx_ff) >= shx) begin
               remx_ff <= 21'(34'(remx_ff) - shx);
            end
            if (34'(remy_ff) >= shy) begin
               remy_ff <= 21'(34'(remy_ff) - shy);
            end
            if (cnt_ff == '0) begin
               state_ff <= S_FOLD;
            end else begin
               cnt_ff <= cnt_ff - 5'd1;
            end
         end
         S_FOLD: begin
            // Nearest image, ties going to the far image.
            absx_ff <= ({remx_ff, 1'b0} >= {1'b0, lenx_ff}) ?
                       20'(lenx_ff - remx_ff) : remx_ff[19:0];
            absy_ff <= ({remy_ff, 1'b0} >= {1'b0, leny_ff}) ?
                       20'(leny_ff - remy_ff) : remy_ff[19:0];
            cnt_ff   <= '0;
            state_ff <= S_SQ;
         end
         S_SQ: begin
            if (cnt_ff[0]) begin
               sq_ff    <= sq_ff + 42'(sqp);
               res_ff   <= '0;
               bit_ff   <= 42'd1 << 40;
               cnt_ff   <= 5'd20;
               state_ff <= S_SQRT;
            end else begin
               sq_ff  <= 42'(sqp);
               cnt_ff <= 5'd1;
            end
         end
         S_SQRT: begin
            if (sq_ff >= trial) begin
               sq_ff  <= sq_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (cnt_ff == '0) begin
               state_ff <= S_CHECK;
            end else begin
               cnt_ff <= cnt_ff - 5'd1;
            end
         end
         S_CHECK: begin
            if (dist_root < 22'(cfg.r_min) || dist_root >= 22'(cfg.r_max)) begin
               hit_ff   <= 1'b0;
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end else begin
               num_ff   <= dist_root - 22'(cfg.r_min);
               cnt_ff   <= 5'd7;
               state_ff <= S_DIV;
            end
         end
         S_DIV: begin
            // The first step only tests whether the quotient reaches 128.
            if (cnt_ff[2:0] == 3'd7) begin
               if (27'(num_ff) >= dsh) begin
                  quot_ff  <= '1;
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= 5'd6;
               end
            end else begin
               if (27'(num_ff) >= dsh) begin
                  num_ff                <= 22'(27'(num_ff) - dsh);
                  quot_ff[cnt_ff[2:0]]  <= 1'b1;
               end
               if (cnt_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - 5'd1;
               end
            end
         end
         default: state_ff <= S_IDLE;
      endcase
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end
   end

   assign geo_rsp.done = done_ff;
   assign geo_rsp.hit  = hit_ff;
   assign geo_rsp.quot = quot_ff;
   assign geo_rsp.re   = {re_ff[PROD_W-2:0], 1'b0};
   assign geo_rsp.im   = {im_ff[PROD_W-2:0], 1'b0};

endmodule

### hw/rtl/hpc_checker.sv
// Port-level checks of the pair-correlation histogram, bound to its top
// level. Depends on hpc_pkg.
module hpc_checker import hpc_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [CMD_W-1:0]        req_command,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [OUT_BIN_W-1:0]    rsp_bin_index,
   input logic signed [SUM_W-1:0] rsp_corr_real_sum,
   input logic [TALLY_W-1:0]      rsp_pair_tally
);

   // A stalled word stays valid and keeps its bin index and real sum.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bin_index) &&
      $stable(rsp_corr_real_sum))
      else $error("stalled response word changed");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Tallies grow by two, so an odd tally can only be the saturated value.
   a_tally: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_pair_tally[0] || (&rsp_pair_tally))
      else $error("odd pair tally below saturation");

   // Only a readout word produces response words.
   a_noword: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command != CMD_READOUT && !rsp_valid
      |=> !rsp_valid)
      else $error("response word without a readout");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_FRAME |=> req_stall)
      else $error("input not stalled during a frame pass");

endmodule

bind hexatic_pair_corr_histogram hpc_checker u_hpc_checker (.*);

### tb/hexatic_pair_corr_histogram_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the hexatic pair-correlation histogram.
// Depends on hpc_pkg and on the RTL top level hexatic_pair_corr_histogram.
module hexatic_pair_corr_histogram_tb;
   import hpc_pkg::*;

   localparam int SLOTS = 1024;
   localparam int BINS = 64;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam logic [TALLY_W-1:0] TALLY_TOP = '1;

   // One readout word as the block should deliver it.
   typedef struct {
      logic [OUT_BIN_W-1:0] bin;
      logic signed [SUM_W-1:0] re_sum;
      logic signed [SUM_W-1:0] im_sum;
      logic [TALLY_W-1:0] tally;
      logic last;
   } bin_word_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [CMD_W-1:0] req_command;
   logic [IDX_W-1:0] req_point_index;
   logic [POS_W-1:0] req_pos_x;
   logic [POS_W-1:0] req_pos_y;
   logic signed [ORD_W-1:0] req_order_re;
   logic signed [ORD_W-1:0] req_order_im;
   logic rsp_valid;
   logic rsp_stall;
   logic [OUT_BIN_W-1:0] rsp_bin_index;
   logic signed [SUM_W-1:0] rsp_corr_real_sum;
   logic signed [SUM_W-1:0] rsp_corr_imag_sum;
   logic [TALLY_W-1:0] rsp_pair_tally;
   logic rsp_last_bin;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // Predictor state: a copy of the registers, the point memory and the bins.
   logic [BOX_W-1:0] cfg_box_w, cfg_box_h;
   logic [CNT_W-1:0] cfg_count;
   logic [POS_W-1:0] cfg_rmin, cfg_rmax, cfg_rstep;
   logic [POS_W-1:0] slot_x [SLOTS];
   logic [POS_W-1:0] slot_y [SLOTS];
   logic signed [ORD_W-1:0] slot_re [SLOTS];
   logic signed [ORD_W-1:0] slot_im [SLOTS];
   logic signed [SUM_W-1:0] hist_re [BINS];
   logic signed [SUM_W-1:0] hist_im [BINS];
   logic [TALLY_W-1:0] hist_tally [BINS];

   bin_word_type pending_bins [$];
   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   longint cycles = 0;

   hexatic_pair_corr_histogram dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // A generous watchdog: the slowest legal run is far below this.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Every accepted response word is compared with the oldest expected bin.
   always @(posedge clock) begin
      bin_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bins.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word: bin %0d", rsp_bin_index);
         end else begin
            want = pending_bins.pop_front();
            if (rsp_bin_index !== want.bin || rsp_corr_real_sum !== want.re_sum ||
                rsp_corr_imag_sum !== want.im_sum || rsp_pair_tally !== want.tally ||
                rsp_last_bin !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("bin word mismatch, expected bin %0d re %0d im %0d tally %0d last %0b",
                           want.bin, want.re_sum, want.im_sum, want.tally, want.last);
                  $display("                   actual   bin %0d re %0d im %0d tally %0d last %0b",
                           rsp_bin_index, rsp_corr_real_sum, rsp_corr_imag_sum,
                           rsp_pair_tally, rsp_last_bin);
               end
            end
         end
      end
   end

   // Minimum-image offset along one axis; the image count is rounded half
   // away from zero, so positions outside the box still fold correctly.
   function automatic longint fold_offset(logic [POS_W-1:0] a, logic [POS_W-1:0] b,
                                          logic [BOX_W-1:0] box);
      longint span, diff, mag, turns, rest;
      span = (box == 0 ? 1 : longint'(box)) * 256;
      diff = longint'(a) - longint'(b);
      mag = diff < 0 ? -diff : diff;
      turns = (2 * mag + span) / (2 * span);
      rest = mag - turns * span;
      return diff < 0 ? -rest : rest;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root, probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   function automatic logic signed [SUM_W-1:0] clamp_add(logic signed [SUM_W-1:0] a,
                                                         logic signed [SUM_W-1:0] b);
      logic signed [SUM_W:0] s;
      s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
      if (s[SUM_W] != s[SUM_W-1])
         return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      return s[SUM_W-1:0];
   endfunction

   // Number of bins the current radius settings give, capped at the bin memory.
   function automatic int bins_in_use();
      longint step, nb;
      step = cfg_rstep == 0 ? 1 : cfg_rstep;
      if (cfg_rmax <= cfg_rmin) return 0;
      nb = (longint'(cfg_rmax) - longint'(cfg_rmin)) / step;
      return nb > BINS ? BINS : int'(nb);
   endfunction

   task automatic accumulate_pairs();
      int n, nb;
      longint dx, dy, step, re_part, im_part;
      longint unsigned dist_root, bin;
      n = cfg_count > SLOTS ? SLOTS : cfg_count;
      nb = bins_in_use();
      step = cfg_rstep == 0 ? 1 : cfg_rstep;
      for (int i = 0; i < n; i++) begin
         for (int j = i + 1; j < n; j++) begin
            dx = fold_offset(slot_x[i], slot_x[j], cfg_box_w);
            dy = fold_offset(slot_y[i], slot_y[j], cfg_box_h);
            dist_root = floor_sqrt(dx * dx + dy * dy);
            if (dist_root < cfg_rmin || dist_root >= cfg_rmax) continue;
            bin = (dist_root - cfg_rmin) / step;
            if (bin >= nb) continue;
            re_part = 2 * (longint'(slot_re[i]) * slot_re[j] +
                           longint'(slot_im[i]) * slot_im[j]);
            im_part = 2 * (longint'(slot_im[i]) * slot_re[j] -
                           longint'(slot_re[i]) * slot_im[j]);
            hist_re[bin] = clamp_add(hist_re[bin], re_part);
            hist_im[bin] = clamp_add(hist_im[bin], im_part);
            hist_tally[bin] = hist_tally[bin] >= TALLY_TOP - 1 ? TALLY_TOP
                              : hist_tally[bin] + 2;
         end
      end
   endtask

   task automatic empty_bins();
      for (int k = 0; k < BINS; k++) begin
         hist_re[k] = 0;
         hist_im[k] = 0;
         hist_tally[k] = 0;
      end
   endtask

   // Applies one accepted word to the predictor and queues the bins it emits.
   task automatic apply_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                             logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic signed [ORD_W-1:0] re, logic signed [ORD_W-1:0] im);
      bin_word_type w;
      int nb;
      case (cmd)
         CMD_LOAD: begin
            slot_x[idx] = x;
            slot_y[idx] = y;
            slot_re[idx] = re;
            slot_im[idx] = im;
         end
         CMD_FRAME: accumulate_pairs();
         CMD_CLEAR: empty_bins();
         default: begin
            nb = bins_in_use();
            for (int k = 0; k < nb; k++) begin
               w.bin = k;
               w.re_sum = hist_re[k];
               w.im_sum = hist_im[k];
               w.tally = hist_tally[k];
               w.last = (k + 1 == nb);
               pending_bins.push_back(w);
            end
         end
      endcase
   endtask

   // Sends one word, idling beforehand at random; valid stays high afterwards
   // so that back-to-back words need no second assignment in one step.
   task automatic send_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                            logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                            logic signed [ORD_W-1:0] re, logic signed [ORD_W-1:0] im);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_command <= $urandom;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_point_index <= idx;
      req_pos_x <= x;
      req_pos_y <= y;
      req_order_re <= re;
      req_order_im <= im;
      do @(posedge clock); while (req_stall);
      apply_word(cmd, idx, x, y, re, im);
   endtask

   // Commands other than a load carry random junk in the unused fields.
   task automatic send_command(logic [CMD_W-1:0] cmd);
      send_word(cmd, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   // Lowers valid and waits until every bin word has arrived and the block
   // has finished any frame pass, which emits nothing of its own.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_bins.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      while (req_stall) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         CSR_BOX_WIDTH: cfg_box_w = data[BOX_W-1:0];
         CSR_BOX_HEIGHT: cfg_box_h = data[BOX_W-1:0];
         CSR_POINT_COUNT: cfg_count = data[CNT_W-1:0];
         CSR_RADIUS_MIN: cfg_rmin = data;
         CSR_RADIUS_MAX: cfg_rmax = data;
         CSR_RADIUS_STEP: cfg_rstep = data;
         default: ;
      endcase
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(int bw, int bh, int rmin, int rmax, int rstep);
      drain();
      write_reg(CSR_BOX_WIDTH, bw);
      write_reg(CSR_BOX_HEIGHT, bh);
      write_reg(CSR_RADIUS_MIN, rmin);
      write_reg(CSR_RADIUS_MAX, rmax);
      write_reg(CSR_RADIUS_STEP, rstep);
   endtask

   // Loads slots 0..n-1 with random points, mostly inside the box.
   task automatic load_frame(int n, bit wild);
      logic [POS_W-1:0] x, y;
      int span_x, span_y;
      span_x = (cfg_box_w == 0 ? 1 : cfg_box_w) * 256;
      span_y = (cfg_box_h == 0 ? 1 : cfg_box_h) * 256;
      for (int i = 0; i < n; i++) begin
         x = wild ? $urandom : $urandom_range(span_x - 1);
         y = wild ? $urandom : $urandom_range(span_y - 1);
         send_word(CMD_LOAD, i, x, y, $urandom, $urandom);
      end
   endtask

   // Directed cases: field extremes, every command, the zero box, the zero
   // step, an empty bin range, positions beyond the box and tiny counts.
   task automatic test_directed();
      set_geometry(4, 4, 0, 1024, 16);
      write_reg(CSR_POINT_COUNT, 4);
      send_word(CMD_LOAD, 0, 0, 0, 16'sh7fff, 16'sh7fff);
      send_word(CMD_LOAD, 1, 20'd300, 20'd1000, -16'sh8000, -16'sh8000);
      send_word(CMD_LOAD, 2, 20'hfffff, 20'hfffff, 16'sh7fff, -16'sh8000);
      send_word(CMD_LOAD, 3, 20'd512, 20'd17, -16'sh8000, 16'sh7fff);
      send_word(CMD_LOAD, 10'd1023, 20'hfffff, 0, 16'sh4000, -16'sh1);
      send_command(CMD_FRAME);
      send_command(CMD_READOUT);
      send_command(CMD_FRAME);
      send_command(CMD_READOUT);
      send_command(CMD_CLEAR);
      send_command(CMD_READOUT);
      // Zero box lengths and a zero step act as one.
      set_geometry(0, 0, 0, 200, 0);
      send_command(CMD_FRAME);
      send_command(CMD_READOUT);
      // An empty radius range yields a readout with no words at all.
      set_geometry(8191, 4096, 20'hfffff, 20'hfffff, 20'hfffff);
      send_command(CMD_FRAME);
      send_command(CMD_READOUT);
      set_geometry(4096, 1, 500, 1, 1);
      send_command(CMD_READOUT);
      // Counts below two give no pairs; the largest count is written once.
      drain();
      write_reg(CSR_POINT_COUNT, 11'h7ff);
      write_reg(CSR_POINT_COUNT, 0);
      set_geometry(2, 2, 1, 20'hfffff, 1);
      send_command(CMD_FRAME);
      drain();
      write_reg(CSR_POINT_COUNT, 1);
      send_command(CMD_FRAME);
      send_command(CMD_READOUT);
   endtask

   // Well-formed frames with random content and geometry, mixed with stray
   // loads, clears and extra readouts.
   task automatic test_random_frames(int words, int idle, int stall);
      int sent, n, bw, step, rmin;
      drain();
      send_idle_pct = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(3) != 0) begin
            bw = $urandom_range(9) == 0 ? 4096 : $urandom_range(1, 16);
            step = $urandom_range(15) == 0 ? 20'hfffff : $urandom_range(1, 300);
            rmin = $urandom_range(9) == 0 ? 0 : $urandom_range(600);
            set_geometry(bw, $urandom_range(9) == 0 ? bw : $urandom_range(1, 16), rmin,
                         $urandom_range(15) == 0 ? $urandom_range(20'hfffff)
                         : rmin + step * $urandom_range(70) + $urandom_range(step),
                         step);
         end
         n = $urandom_range(2, 8);
         drain();
         write_reg(CSR_POINT_COUNT, n);
         load_frame(n, $urandom_range(7) == 0);
         sent += n;
         if ($urandom_range(4) == 0) begin
            send_word(CMD_LOAD, $urandom_range(n, SLOTS - 1), $urandom, $urandom,
                      $urandom, $urandom);
            send_command($urandom_range(1) ? CMD_CLEAR : CMD_READOUT);
            sent += 2;
         end
         send_command(CMD_FRAME);
         send_command(CMD_READOUT);
         sent += 2;
      end
   endtask

   initial begin
      reset = 1'b1;
      rsp_stall = 1'b0;
      req_valid = 1'b0;
      req_command = CMD_LOAD;
      req_point_index = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_order_re = '0;
      req_order_im = '0;
      csr_write_en = 1'b0;
      csr_index = CSR_BOX_WIDTH;
      csr_write_data = '0;
      cfg_box_w = 256;
      cfg_box_h = 256;
      cfg_count = 1024;
      cfg_rmin = 0;
      cfg_rmax = 8192;
      cfg_rstep = 256;
      empty_bins();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_frames(50, 0, 0);
      test_random_frames(50, 80, 0);
      test_random_frames(50, 0, 80);
      test_random_frames(50, 24, 24);

      drain();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_bins.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### hexatic_pair_corr_histogram.f
hw/rtl/hpc_pkg.sv
hw/rtl/hpc_ram.sv
hw/rtl/hpc_geom.sv
hw/rtl/hexatic_pair_corr_histogram.sv
hw/rtl/hpc_checker.sv
tb/hexatic_pair_corr_histogram_tb.sv
